[src/activity_led_blink_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// Activity LED blink sequencer assertion macros
// Shared concurrent assertion helpers, sampled on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ACTIVITY_LED_BLINK_SEQUENCER_MACROS_SVH
`define ACTIVITY_LED_BLINK_SEQUENCER_MACROS_SVH

// same-cycle implication
`define ALBS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ALBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/albs_pkg.sv]
// ----------------------------------------------------------------------------
// Activity LED blink sequencer package
// Action codes, pattern ids, blink interval tables and shared types.
// ----------------------------------------------------------------------------
package albs_pkg;

	localparam int unsigned RATE_W     = 32;
	localparam int unsigned MS_W       = 10;
	localparam int unsigned STEP_W     = 4;
	localparam int unsigned PAT_W      = 3;
	localparam int unsigned PAT_NUM    = 5;
	localparam int unsigned PAT_MAXLEN = 8;

	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_NONMEDIA = 2'd1,
		ACT_RATE     = 2'd2
	} albs_action_t;

	localparam logic [PAT_W-1:0] PAT_POWER_ON = 3'd0;
	localparam logic [PAT_W-1:0] PAT_NONMEDIA = 3'd1;
	localparam logic [PAT_W-1:0] PAT_LOW      = 3'd2;
	localparam logic [PAT_W-1:0] PAT_MED      = 3'd3;
	localparam logic [PAT_W-1:0] PAT_HIGH     = 3'd4;

	localparam logic [MS_W-1:0] IDLE_MS = 10'd1000;

	localparam logic [RATE_W-1:0] LOW_LIMIT_RST  = 32'd200;
	localparam logic [RATE_W-1:0] HIGH_LIMIT_RST = 32'd400;

	// config register indexes
	localparam logic CFG_LOW_LIMIT  = 1'b0;
	localparam logic CFG_HIGH_LIMIT = 1'b1;

	localparam logic [MS_W-1:0] PAT_MS [PAT_NUM][PAT_MAXLEN] = '{
		'{10'd500, 10'd500, 10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0  },
		'{10'd250, 10'd250, 10'd250, 10'd250, 10'd0,   10'd0,   10'd0,   10'd0  },
		'{10'd200, 10'd200, 10'd200, 10'd200, 10'd200, 10'd0,   10'd0,   10'd0  },
		'{10'd160, 10'd170, 10'd160, 10'd170, 10'd170, 10'd170, 10'd0,   10'd0  },
		'{10'd120, 10'd130, 10'd120, 10'd130, 10'd120, 10'd130, 10'd120, 10'd130}
	};

	localparam logic [STEP_W-1:0] PAT_LEN [PAT_NUM] = '{4'd2, 4'd4, 4'd5, 4'd6, 4'd8};

	typedef struct packed {
		logic led_on;
		logic interval_started;
	} albs_result_t;

	function automatic logic [MS_W-1:0] pat_interval(logic [PAT_W-1:0] id, logic [2:0] step);
		logic [MS_W-1:0] ms;
		ms = '0;
		if (id < PAT_W'(PAT_NUM))
			ms = PAT_MS[id][step];
		return ms;
	endfunction

	function automatic logic [STEP_W-1:0] pat_length(logic [PAT_W-1:0] id);
		logic [STEP_W-1:0] len;
		len = '0;
		if (id < PAT_W'(PAT_NUM))
			len = PAT_LEN[id];
		return len;
	endfunction

endpackage

[src/albs_if.sv]
// ----------------------------------------------------------------------------
// Activity LED blink sequencer channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface albs_in_if
	import albs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [RATE_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

interface albs_out_if;
	logic valid;
	logic ready;
	logic led_on;
	logic interval_started;

	modport source (output valid, output led_on, output interval_started, input ready);
	modport sink (input valid, input led_on, input interval_started, output ready);
endinterface

[src/albs_core.sv]
// ----------------------------------------------------------------------------
// Activity LED blink sequencer core
// Pattern state, rate limits and the per-word next-state logic.
// ----------------------------------------------------------------------------
module albs_core
	import albs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [1:0]        action,
	input  logic [RATE_W-1:0] value,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [RATE_W-1:0] cfg_data,
	output albs_result_t      result
);

	logic [RATE_W-1:0] low_limit_q, high_limit_q;
	logic [PAT_W-1:0]  pat_q, pat_n;
	logic [STEP_W-1:0] step_q, step_n;
	logic [MS_W-1:0]   rem_q, rem_n;
	logic              led_q, led_n;
	logic              pend_q, pend_n;
	logic [RATE_W-1:0] rate_q, rate_n;
	logic              started;

	logic              at_end;
	logic              choose_ok;
	logic [PAT_W-1:0]  choose_pat;

	assign at_end = (pat_q >= PAT_W'(PAT_NUM)) || (step_q >= pat_length(pat_q));

	always_comb begin
		choose_ok  = 1'b1;
		choose_pat = PAT_HIGH;
		if (rate_q == '0) begin
			choose_ok  = pend_q;
			choose_pat = PAT_NONMEDIA;
		end else if (rate_q < low_limit_q) begin
			choose_pat = PAT_LOW;
		end else if (rate_q < high_limit_q) begin
			choose_pat = PAT_MED;
		end
	end

	always_comb begin
		pat_n   = pat_q;
		step_n  = step_q;
		rem_n   = rem_q;
		led_n   = led_q;
		pend_n  = pend_q;
		rate_n  = rate_q;
		started = 1'b0;
		unique case (action)
			ACT_TICK: begin
				if (rem_q > MS_W'(1)) begin
					rem_n = rem_q - MS_W'(1);
				end else begin
					started = 1'b1;
					if (!at_end) begin
						led_n  = ~led_q;
						rem_n  = pat_interval(pat_q, step_q[2:0]);
						step_n = step_q + STEP_W'(1);
					end else if (choose_ok) begin
						pat_n  = choose_pat;
						led_n  = 1'b1;
						rem_n  = pat_interval(choose_pat, 3'd0);
						step_n = STEP_W'(1);
						pend_n = 1'b0;
						rate_n = '0;
					end else begin
						// nothing going on: dark for the idle interval, retry later
						led_n = 1'b0;
						rem_n = IDLE_MS;
					end
				end
			end
			ACT_NONMEDIA: pend_n = |value;
			ACT_RATE:     rate_n = value;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q  <= LOW_LIMIT_RST;
			high_limit_q <= HIGH_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOW_LIMIT:  low_limit_q  <= cfg_data;
				CFG_HIGH_LIMIT: high_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= PAT_POWER_ON;
			step_q <= STEP_W'(1);
			rem_q  <= pat_interval(PAT_POWER_ON, 3'd0);
			led_q  <= 1'b1;
			pend_q <= 1'b0;
			rate_q <= '0;
		end else if (fire) begin
			pat_q  <= pat_n;
			step_q <= step_n;
			rem_q  <= rem_n;
			led_q  <= led_n;
			pend_q <= pend_n;
			rate_q <= rate_n;
		end
	end

	assign result.led_on           = led_n;
	assign result.interval_started = started;

endmodule

[src/activity_led_blink_sequencer.sv]
// ----------------------------------------------------------------------------
// Activity LED blink sequencer
// Activity LED driver: 1 ms ticks and activity reports in, LED state out.
// ----------------------------------------------------------------------------
// in_ch carries one word per tick or report (action, value); out_ch returns
// exactly one word per input word (led_on, interval_started).
// cfg_we/cfg_index/cfg_data write the low and high rate limits; write only
// while no word is in flight.
// An accepted word sits in the input register until it fires; its result is
// computed and loaded into the output register at that edge, where out_ch.valid
// rises as well, and the result word is held there until out_ch takes it.
// Throughput is one word per cycle while out_ch does not stall: the whole
// pattern state update is combinational logic behind the input register.
// When out_ch stalls, the output register holds its word and the input
// register still takes one more word; after that in_ch.ready drops until
// the result is taken.
// After reset the power-on pattern runs (lit 500 ms, dark 500 ms), the limits
// are 200 and 400, both activity reports are cleared and both registers are
// empty.
// ----------------------------------------------------------------------------
`include "activity_led_blink_sequencer_macros.svh"

module activity_led_blink_sequencer
	import albs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	albs_in_if.sink           in_ch,
	albs_out_if.source        out_ch,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [RATE_W-1:0] cfg_data
);

	logic              valid_s1;
	logic [1:0]        action_s1;
	logic [RATE_W-1:0] value_s1;
	logic              out_valid_q;
	albs_result_t      out_word_q;
	albs_result_t      result;
	logic              advance;
	logic              fire;

	assign advance     = !out_valid_q || out_ch.ready;
	assign fire        = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			action_s1 <= in_ch.action;
			value_s1  <= in_ch.value;
		end
	end

	albs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.action    (action_s1),
		.value     (value_s1),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_word_q <= result;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.led_on           = out_word_q.led_on;
	assign out_ch.interval_started = out_word_q.interval_started;

	// a report or unused code never starts an interval nor moves the led
	`ALBS_ASSERT_NEXT(a_report_no_interval,
		fire && action_s1 != ACT_TICK,
		!out_ch.interval_started,
		"report word started an interval")
	`ALBS_ASSERT_SAME(a_report_keeps_led,
		fire && action_s1 != ACT_TICK && out_valid_q,
		result.led_on == out_word_q.led_on,
		"report word changed the led")
	// a word held in the input register while the output is blocked stays put
	`ALBS_ASSERT_NEXT(a_s1_hold,
		valid_s1 && !advance,
		valid_s1 && $stable(action_s1) && $stable(value_s1),
		"input register lost a word under stall")
	// result register fills only from a word that was in the input register
	`ALBS_ASSERT_NEXT(a_out_from_s1,
		!valid_s1 && advance,
		!out_ch.valid,
		"result word without a source word")

endmodule
